### design/sms_pkg.sv
// shared types, codes and defaults of the switch matrix scanner
package sms_pkg;

  localparam int DEF_MAX_ROW_COUNT    = 16;
  localparam int DEF_MAX_COLUMN_COUNT = 32;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 32;

  // register indexes of the configuration port
  localparam logic [CFG_INDEX_W-1:0] REG_ROW_COUNT        = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_COLUMN_COUNT     = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_SCAN_PERIOD      = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_ACTIVE_LOW       = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_ROWS_MULTIPLEXED = 3'd4;

  // register values after reset
  localparam logic [4:0]  RST_ROW_COUNT        = 5'd1;
  localparam logic [5:0]  RST_COLUMN_COUNT     = 6'd32;
  localparam logic [31:0] RST_SCAN_PERIOD      = 32'd1000;
  localparam logic        RST_ACTIVE_LOW       = 1'b1;
  localparam logic        RST_ROWS_MULTIPLEXED = 1'b0;

  // result item kinds
  typedef enum logic [1:0] {
    KIND_IDLE  = 2'd0,
    KIND_EVENT = 2'd1,
    KIND_STEP  = 2'd2
  } kind_t;

  // controller to datapath
  typedef struct packed {
    logic load;         // capture column levels, bump tick count
    logic eval;         // decide on a row step, sample and compare
    logic shift;        // look at one column of the difference word
    logic emit_status;  // issue the closing status item of the tick
  } sms_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic step_due;     // tick count exceeds the scan period
    logic diff_empty;   // no changed columns left to report
    logic out_free;     // output register can take an item this cycle
  } sms_stat_t;

endpackage

### design/sms_ctrl.sv
// controller state machine of the switch matrix scanner
module sms_ctrl
  import sms_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  sms_stat_t stat,
  output sms_cmd_t  cmd
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_EVAL   = 4'b0010,
    ST_SCAN   = 4'b0100,
    ST_STATUS = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_EVAL;
        end
      end
      ST_EVAL: begin
        cmd.eval  = 1'b1;
        state_nxt = stat.step_due ? ST_SCAN : ST_STATUS;
      end
      ST_SCAN: begin
        if (stat.diff_empty) begin
          state_nxt = ST_STATUS;
        end else if (stat.out_free) begin
          cmd.shift = 1'b1;
        end
      end
      ST_STATUS: begin
        if (stat.out_free) begin
          cmd.emit_status = 1'b1;
          state_nxt       = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### design/sms_datapath.sv
// datapath of the switch matrix scanner: config, counters, row store, output register
module sms_datapath
  import sms_pkg::*;
#(
  parameter int MAX_ROW_COUNT    = DEF_MAX_ROW_COUNT,
  parameter int MAX_COLUMN_COUNT = DEF_MAX_COLUMN_COUNT
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  sms_cmd_t               cmd,
  output sms_stat_t              stat,
  input  logic [31:0]            in_column_levels,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [1:0]             out_kind,
  output logic [3:0]             out_event_row,
  output logic [4:0]             out_event_column,
  output logic                   out_event_closed,
  output logic [15:0]            out_row_drive,
  output logic                   out_scan_done,
  output logic                   out_matrix_changed,
  output logic                   out_last
);

  localparam int STORE_DEPTH = (MAX_ROW_COUNT < 16) ? MAX_ROW_COUNT : 16;
  localparam int ROW_IDX_W   = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int COL_W       = MAX_COLUMN_COUNT;
  localparam logic [4:0] ROWS_MAX = 5'(STORE_DEPTH);
  localparam logic [5:0] COLS_MAX = 6'(COL_W);

  function automatic logic [15:0] drive_pattern(input logic [3:0] row, input logic mux,
                                                input logic low);
    logic [15:0] onehot;
    onehot = 16'd1 << row;
    if (mux) begin
      return {12'd0, row};
    end else if (low) begin
      return ~onehot;
    end
    return onehot;
  endfunction

  // configuration
  logic [4:0]  row_count_r;
  logic [5:0]  column_count_r;
  logic [31:0] scan_period_r;
  logic        active_low_r;
  logic        rows_mux_r;

  // scan state
  logic [31:0]      tick_r;
  logic [3:0]       row_r;
  logic             changed_r;
  logic [COL_W-1:0] store_r [STORE_DEPTH];

  // per-tick work registers
  logic [31:0]      levels_r;
  logic             step_r;
  logic [COL_W-1:0] diff_r;
  logic [COL_W-1:0] sample_r;
  logic [4:0]       col_cnt_r;
  logic [3:0]       ev_row_r;

  // output register
  logic        out_valid_r, out_valid_nxt;
  kind_t       out_kind_r;
  logic [3:0]  out_event_row_r;
  logic [4:0]  out_event_column_r;
  logic        out_event_closed_r;
  logic [15:0] out_row_drive_r;
  logic        out_scan_done_r;
  logic        out_matrix_changed_r;
  logic        out_last_r;

  logic [4:0]           rows_in_use;
  logic [5:0]           cols_in_use;
  logic [COL_W-1:0]     col_mask;
  logic [COL_W-1:0]     sample;
  logic [COL_W-1:0]     diff;
  logic [ROW_IDX_W-1:0] row_idx;
  logic [31:0]          tick_inc;
  logic [4:0]           row_p1;
  logic                 wrap;
  logic                 done;
  logic [3:0]           row_new;
  logic                 event_load;

  always_comb begin
    if (row_count_r == 5'd0) begin
      rows_in_use = 5'd1;
    end else if (row_count_r > ROWS_MAX) begin
      rows_in_use = ROWS_MAX;
    end else begin
      rows_in_use = row_count_r;
    end
  end

  assign cols_in_use = (column_count_r > COLS_MAX) ? COLS_MAX : column_count_r;

  always_comb begin
    for (int i = 0; i < COL_W; i++) begin
      col_mask[i] = (6'(i) < cols_in_use);
    end
  end

  assign sample   = (active_low_r ? ~levels_r[COL_W-1:0] : levels_r[COL_W-1:0]) & col_mask;
  assign row_idx  = row_r[ROW_IDX_W-1:0];
  assign diff     = sample ^ store_r[row_idx];
  assign tick_inc = (tick_r == '1) ? tick_r : tick_r + 32'd1;

  assign row_p1  = {1'b0, row_r} + 5'd1;
  assign wrap    = (row_p1 >= rows_in_use);
  assign done    = step_r & wrap;
  assign row_new = !step_r ? row_r : (wrap ? 4'd0 : row_p1[3:0]);

  assign event_load = cmd.shift & diff_r[0];

  assign stat.step_due   = (tick_r > scan_period_r);
  assign stat.diff_empty = (diff_r == '0);
  assign stat.out_free   = !out_valid_r || !out_stall;

  assign out_valid_nxt = (event_load || cmd.emit_status) ? 1'b1 : (out_valid_r && out_stall);

  // control state and row store
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r    <= RST_ROW_COUNT;
      column_count_r <= RST_COLUMN_COUNT;
      scan_period_r  <= RST_SCAN_PERIOD;
      active_low_r   <= RST_ACTIVE_LOW;
      rows_mux_r     <= RST_ROWS_MULTIPLEXED;
      tick_r         <= '0;
      row_r          <= '0;
      changed_r      <= 1'b0;
      out_valid_r    <= 1'b0;
      for (int i = 0; i < STORE_DEPTH; i++) begin
        store_r[i] <= '0;
      end
    end else begin
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_ROW_COUNT:        row_count_r    <= cfg_data[4:0];
          REG_COLUMN_COUNT:     column_count_r <= cfg_data[5:0];
          REG_SCAN_PERIOD:      scan_period_r  <= cfg_data[31:0];
          REG_ACTIVE_LOW:       active_low_r   <= cfg_data[0];
          REG_ROWS_MULTIPLEXED: rows_mux_r     <= cfg_data[0];
          default: ;
        endcase
      end
      if (cmd.load) begin
        tick_r <= tick_inc;
      end
      if (cmd.eval && stat.step_due) begin
        tick_r           <= '0;
        store_r[row_idx] <= sample;
        if (diff != '0) begin
          changed_r <= 1'b1;
        end
      end
      if (cmd.emit_status) begin
        row_r <= row_new;
        if (done) begin
          changed_r <= 1'b0;
        end
      end
    end
  end

  // work registers and output payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      levels_r <= in_column_levels;
    end
    if (cmd.eval) begin
      step_r    <= stat.step_due;
      diff_r    <= stat.step_due ? diff : '0;
      sample_r  <= sample;
      col_cnt_r <= 5'd0;
      ev_row_r  <= row_r;
    end
    if (cmd.shift) begin
      diff_r    <= diff_r >> 1;
      sample_r  <= sample_r >> 1;
      col_cnt_r <= col_cnt_r + 5'd1;
    end
    if (event_load) begin
      out_kind_r           <= KIND_EVENT;
      out_event_row_r      <= ev_row_r;
      out_event_column_r   <= col_cnt_r;
      out_event_closed_r   <= sample_r[0];
      out_row_drive_r      <= '0;
      out_scan_done_r      <= 1'b0;
      out_matrix_changed_r <= 1'b0;
      out_last_r           <= 1'b0;
    end else if (cmd.emit_status) begin
      out_kind_r           <= step_r ? KIND_STEP : KIND_IDLE;
      out_event_row_r      <= '0;
      out_event_column_r   <= '0;
      out_event_closed_r   <= 1'b0;
      out_row_drive_r      <= drive_pattern(row_new, rows_mux_r, active_low_r);
      out_scan_done_r      <= done;
      out_matrix_changed_r <= done & changed_r;
      out_last_r           <= 1'b1;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_kind           = out_kind_r;
  assign out_event_row      = out_event_row_r;
  assign out_event_column   = out_event_column_r;
  assign out_event_closed   = out_event_closed_r;
  assign out_row_drive      = out_row_drive_r;
  assign out_scan_done      = out_scan_done_r;
  assign out_matrix_changed = out_matrix_changed_r;
  assign out_last           = out_last_r;

endmodule

### design/switch_matrix_scanner.sv
// top level of the switch matrix scanner
// an idle tick goes from the eval state to the status state, which loads its status item into
// the output register once it can take an item; a row step first scans its changed columns
// a new tick is taken only in the idle state, once the status item of the last one is issued;
//   the difference scan looks at one column per cycle while the output register can take an item
// reset (rst_n, synchronous): config to defaults, tick counter, row index and row store to zero
module switch_matrix_scanner
  import sms_pkg::*;
#(
  parameter int MAX_ROW_COUNT    = DEF_MAX_ROW_COUNT,
  parameter int MAX_COLUMN_COUNT = DEF_MAX_COLUMN_COUNT
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // tick items
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [31:0]            in_column_levels,
  // configuration writes
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  // result items
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [1:0]             out_kind,
  output logic [3:0]             out_event_row,
  output logic [4:0]             out_event_column,
  output logic                   out_event_closed,
  output logic [15:0]            out_row_drive,
  output logic                   out_scan_done,
  output logic                   out_matrix_changed,
  output logic                   out_last
);

  sms_cmd_t  cmd;
  sms_stat_t stat;

  // controller walks idle -> eval -> (scan) -> status, one tick at a time
  sms_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // datapath holds config, tick counter, row store and the output register;
  // the output register lets the next item in while a status item waits
  sms_datapath #(
    .MAX_ROW_COUNT    (MAX_ROW_COUNT),
    .MAX_COLUMN_COUNT (MAX_COLUMN_COUNT)
  ) u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .in_column_levels   (in_column_levels),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_kind           (out_kind),
    .out_event_row      (out_event_row),
    .out_event_column   (out_event_column),
    .out_event_closed   (out_event_closed),
    .out_row_drive      (out_row_drive),
    .out_scan_done      (out_scan_done),
    .out_matrix_changed (out_matrix_changed),
    .out_last           (out_last)
  );

  // an accepted item keeps the input closed for at least the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input open right after an item was accepted");

  // a waiting change event means its tick is still being worked on
  a_event_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_EVENT |-> in_stall && !out_last)
    else $error("change event pending while the block is idle");

  // end of scan only comes with a row step status
  a_done_on_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_scan_done |-> out_kind == KIND_STEP && out_last)
    else $error("scan done flagged outside a row step status");

  // matrix changed only reported at end of scan
  a_changed_needs_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_matrix_changed |-> out_scan_done)
    else $error("matrix changed without end of scan");

endmodule
